@@ design/rce_pkg.sv @@
// rce_pkg: shared widths, register reset values, register indexes and the
// front-to-back control record of the route cost evaluator.
// No dependencies.
package rce_pkg;

  localparam int unsigned AISLE_W  = 12;
  localparam int unsigned CAP_W    = 16;
  localparam int unsigned PF_W     = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned LOAD_W   = 24;
  localparam int unsigned PEN_W    = 32;

  localparam logic [AISLE_W-1:0] AISLE_RST = AISLE_W'(500);
  localparam logic [CAP_W-1:0]   CAP_RST   = CAP_W'(25);
  localparam logic [PF_W-1:0]    PF_RST    = PF_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AISLE = 2'd0,
    CFG_CAP   = 2'd1,
    CFG_PF    = 2'd2
  } rce_cfg_idx_e;

  // Per-stop record handed from the front to the back
  typedef struct packed {
    logic              last;     // route ends with this stop
    logic              clr_pen;  // first stop or depot visit: penalty drops to zero
    logic              upd_pen;  // load over capacity: penalty = factor * excess
    logic [LOAD_W-1:0] excess;   // load minus capacity
  } rce_ctl_t;

endpackage

@@ design/route_cost_evaluator.sv @@
// Channel   Handshake        Beat contents
// stops     push / full      stop_x_i, stop_y_i, stop_weight_i, last_stop_i
// results   pop / empty      route_cost_o, cost_saturated_o
// config    cfg_we_i         cfg_idx_i, cfg_data_i (no stall, no read-back)
//
// One stop per cycle sustained: the front takes a stop every cycle while the
// two-entry queue has room; the back consumes one queue entry per cycle.
// A route's result passes the queue, stage 1 and the result register.
// The back stalls only when a finished result waits and pop stays low; the
// queue then fills and full rises. Reset clears route state and restores
// register defaults; no clearing pass.
// Depends on rce_pkg, rce_front, rce_fifo, rce_back.
module route_cost_evaluator import rce_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COST_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [COORD_BITS-1:0] stop_x_i,
  input  logic [COORD_BITS-1:0] stop_y_i,
  input  logic [WEIGHT_W-1:0]   stop_weight_i,
  input  logic                  last_stop_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [COST_BITS-1:0]  route_cost_o,
  output logic                  cost_saturated_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned DSW    = COORD_BITS + 3;
  localparam int unsigned REC_W  = $bits(rce_ctl_t) + DSW;
  localparam int unsigned QDEPTH = 2;

  logic [AISLE_W-1:0] aisle_q;
  logic [CAP_W-1:0]   cap_q;
  logic [PF_W-1:0]    pf_q;

  logic               accept;
  rce_ctl_t           f_ctl, b_ctl;
  logic [DSW-1:0]     f_dist, b_dist;
  logic               q_valid, q_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aisle_q <= AISLE_RST;
      cap_q   <= CAP_RST;
      pf_q    <= PF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AISLE: aisle_q <= cfg_data_i[AISLE_W-1:0];
        CFG_CAP:   cap_q   <= cfg_data_i[CAP_W-1:0];
        CFG_PF:    pf_q    <= cfg_data_i[PF_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  rce_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .stop_x_i     (stop_x_i),
    .stop_y_i     (stop_y_i),
    .stop_weight_i(stop_weight_i),
    .last_stop_i  (last_stop_i),
    .aisle_i      (aisle_q),
    .cap_i        (cap_q),
    .ctl_o        (f_ctl),
    .dist_o       (f_dist)
  );

  rce_fifo #(
    .W    (REC_W),
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (accept),
    .wdata_i({f_ctl, f_dist}),
    .rd_i   (q_rd),
    .rdata_o({b_ctl, b_dist}),
    .full_o (full),
    .valid_o(q_valid)
  );

  rce_back #(
    .COORD_BITS(COORD_BITS),
    .COST_BITS (COST_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .ctl_i           (b_ctl),
    .dist_i          (b_dist),
    .pf_i            (pf_q),
    .q_rd_o          (q_rd),
    .pop_i           (pop),
    .empty_o         (empty),
    .route_cost_o    (route_cost_o),
    .cost_saturated_o(cost_saturated_o)
  );

endmodule

@@ design/rce_front.sv @@
// rce_front: per-stop classification, load tracking and leg distances.
// Depends on rce_pkg.
module rce_front import rce_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [COORD_BITS-1:0] stop_x_i,
  input  logic [COORD_BITS-1:0] stop_y_i,
  input  logic [WEIGHT_W-1:0]   stop_weight_i,
  input  logic                  last_stop_i,
  input  logic [AISLE_W-1:0]    aisle_i,
  input  logic [CAP_W-1:0]      cap_i,
  output rce_ctl_t              ctl_o,
  output logic [COORD_BITS+2:0] dist_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = CW + 2;
  localparam int unsigned SW = ((CW > AISLE_W) ? CW : AISLE_W) + 3;

  function automatic logic [DW-1:0] leg_dist(
    input logic [CW-1:0]      x1,
    input logic [CW-1:0]      y1,
    input logic [CW-1:0]      x2,
    input logic [CW-1:0]      y2,
    input logic [AISLE_W-1:0] aisle
  );
    logic [CW-1:0]        h;
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] m;
    logic [CW:0]          v;
    h = (x1 > x2) ? (x1 - x2) : (x2 - x1);
    s = SW'(y1) + SW'(y2);
    m = SW'({aisle, 1'b0}) - s;
    if (h != '0) begin
      // different aisles: shorter detour over row 0 or the row limit
      if (m < s) begin
        v = (m < 0) ? '0 : m[CW:0];
      end else begin
        v = s[CW:0];
      end
    end else begin
      v = {1'b0, ((y1 > y2) ? (y1 - y2) : (y2 - y1))};
    end
    return DW'(h) + DW'(v);
  endfunction

  logic [CW-1:0]     prev_x_q, prev_x_d;
  logic [CW-1:0]     prev_y_q, prev_y_d;
  logic [LOAD_W-1:0] load_q, load_d;
  logic              first_q, first_d;

  logic [DW-1:0]     leg, ret_leg;
  logic [LOAD_W:0]   load_sum;
  logic [LOAD_W-1:0] load_sat;
  logic              at_depot;

  assign leg     = first_q ? leg_dist('0, '0, stop_x_i, stop_y_i, aisle_i)
                           : leg_dist(prev_x_q, prev_y_q, stop_x_i, stop_y_i, aisle_i);
  assign ret_leg = leg_dist(stop_x_i, stop_y_i, '0, '0, aisle_i);
  assign at_depot = (stop_x_i == '0) && (stop_y_i == '0);

  assign load_sum = {1'b0, load_q} + (LOAD_W+1)'(stop_weight_i);
  assign load_sat = load_sum[LOAD_W] ? '1 : load_sum[LOAD_W-1:0];

  always_comb begin
    ctl_o.last    = last_stop_i;
    ctl_o.clr_pen = 1'b0;
    ctl_o.upd_pen = 1'b0;
    ctl_o.excess  = load_sat - LOAD_W'(cap_i);
    load_d        = load_sat;
    if (first_q) begin
      ctl_o.clr_pen = 1'b1;
      load_d        = LOAD_W'(stop_weight_i);
    end else if (at_depot) begin
      ctl_o.clr_pen = 1'b1;
      load_d        = '0;
    end else begin
      ctl_o.upd_pen = load_sat > LOAD_W'(cap_i);
    end
    dist_o   = (DW+1)'(leg) + (last_stop_i ? (DW+1)'(ret_leg) : '0);
    prev_x_d = stop_x_i;
    prev_y_d = stop_y_i;
    first_d  = last_stop_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      load_q   <= '0;
      first_q  <= 1'b1;
    end else if (accept_i) begin
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      load_q   <= load_d;
      first_q  <= first_d;
    end
  end

endmodule

@@ design/rce_fifo.sv @@
// rce_fifo: short queue between front and back.
// No dependencies.
module rce_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  input  logic         rd_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         valid_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (rd_i) begin
        rptr_q <= ptr_inc(rptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ design/rce_back.sv @@
// rce_back: penalty multiply, saturating cost accumulation and result register.
// Depends on rce_pkg.
module rce_back import rce_pkg::*; #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned COST_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  rce_ctl_t              ctl_i,
  input  logic [COORD_BITS+2:0] dist_i,
  input  logic [PF_W-1:0]       pf_i,
  output logic                  q_rd_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [COST_BITS-1:0]  route_cost_o,
  output logic                  cost_saturated_o
);

  localparam int unsigned DSW = COORD_BITS + 3;
  localparam int unsigned AW  = ((COST_BITS > PEN_W + 1) ? COST_BITS : PEN_W + 1) + 1;

  // stage 1: item with its penalty
  logic                 s1_v_q;
  logic                 s1_last_q;
  logic [DSW-1:0]       s1_dist_q;
  logic [PEN_W-1:0]     pen_q, pen_d;

  logic [COST_BITS-1:0] total_q;
  logic                 clip_q;

  logic                 out_v_q;
  logic [COST_BITS-1:0] out_cost_q;
  logic                 out_sat_q;

  logic                 s1_adv, s1_ld;
  logic [AW-1:0]        sum;
  logic                 over;
  logic [COST_BITS-1:0] total_new;
  logic                 clip_new;

  assign s1_adv = s1_v_q && (!s1_last_q || !out_v_q || pop_i);
  assign s1_ld  = q_valid_i && (!s1_v_q || s1_adv);
  assign q_rd_o = s1_ld;

  always_comb begin
    pen_d = pen_q;
    if (ctl_i.clr_pen) begin
      pen_d = '0;
    end else if (ctl_i.upd_pen) begin
      pen_d = PEN_W'(pf_i) * PEN_W'(ctl_i.excess);
    end
  end

  assign sum       = AW'(total_q) + AW'(s1_dist_q) + AW'(pen_q);
  assign over      = sum > AW'({COST_BITS{1'b1}});
  assign total_new = over ? '1 : sum[COST_BITS-1:0];
  assign clip_new  = clip_q | over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      s1_dist_q <= '0;
      pen_q     <= '0;
      total_q   <= '0;
      clip_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (s1_ld) begin
        s1_v_q    <= 1'b1;
        s1_last_q <= ctl_i.last;
        s1_dist_q <= dist_i;
        pen_q     <= pen_d;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_last_q) begin
          total_q <= '0;
          clip_q  <= 1'b0;
        end else begin
          total_q <= total_new;
          clip_q  <= clip_new;
        end
      end
      if (s1_adv && s1_last_q) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_cost_q <= total_new;
      out_sat_q  <= clip_new;
    end
  end

  assign empty_o          = !out_v_q;
  assign route_cost_o     = out_cost_q;
  assign cost_saturated_o = out_sat_q;

endmodule

@@ design/rce_checker.sv @@
// rce_checker: port-level checks of the route cost evaluator, bound to the top.
// Depends on rce_pkg and route_cost_evaluator.
module rce_checker import rce_pkg::*; #(
  parameter int unsigned COST_BITS = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input logic                 last_stop_i,
  input logic                 empty,
  input logic                 pop,
  input logic [COST_BITS-1:0] route_cost_o,
  input logic                 cost_saturated_o
);

  // routes closed at the input and not yet taken at the output
  logic [2:0] pend_q, pend_d;
  logic       in_last, out_beat;

  assign in_last  = push && !full && last_stop_i;
  assign out_beat = pop && !empty;

  always_comb begin
    pend_d = pend_q;
    if (in_last && !out_beat) begin
      pend_d = pend_q + 1'b1;
    end else if (out_beat && !in_last) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_result_has_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pend_q != '0)
    else $error("result shown without a finished route");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("more routes in flight than pipeline holds");

  a_sat_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && cost_saturated_o) |-> route_cost_o == {COST_BITS{1'b1}})
    else $error("saturated result is not at maximum");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(route_cost_o) && $stable(cost_saturated_o)))
    else $error("waiting result changed");

endmodule

bind route_cost_evaluator rce_checker #(
  .COST_BITS(COST_BITS)
) u_rce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .push            (push),
  .full            (full),
  .last_stop_i     (last_stop_i),
  .empty           (empty),
  .pop             (pop),
  .route_cost_o    (route_cost_o),
  .cost_saturated_o(cost_saturated_o)
);
